// File: rtl/core/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// shared types and constants for the bank mapper with scanline interrupt
// ----------------------------------------------------------------------------
package bmsi_pkg;

  localparam int unsigned RAM_DEPTH_DEFAULT = 8192;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned TARGET_W = 3;
  localparam int unsigned MAP_W    = 19;

  // fixed prg banks for the swappable windows
  localparam logic [5:0] PRG_BANK_SECOND_LAST = 6'h3e;
  localparam logic [5:0] PRG_BANK_LAST        = 6'h3f;

  // a12 edge filter restart value, in cpu ticks
  localparam logic [2:0] FILTER_RELOAD = 3'd6;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_CPU_RD = 3'd1,
    MODE_CPU_WR = 3'd2,
    MODE_PPU_RD = 3'd3,
    MODE_PPU_WR = 3'd4
  } mode_t;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE     = 3'd0,
    TGT_OPEN_BUS = 3'd1,
    TGT_PRG_RAM  = 3'd2,
    TGT_PRG_ROM  = 3'd3,
    TGT_CHR      = 3'd4,
    TGT_NAMETBL  = 3'd5
  } target_t;

  // register select: {address[14:13], address[0]} for writes at 0x8000 and up
  typedef enum logic [2:0] {
    REG_BANK_SEL   = 3'b000,
    REG_BANK_DATA  = 3'b001,
    REG_MIRROR     = 3'b010,
    REG_RAM_CTRL   = 3'b011,
    REG_IRQ_LATCH  = 3'b100,
    REG_IRQ_RELOAD = 3'b101,
    REG_IRQ_DIS    = 3'b110,
    REG_IRQ_EN     = 3'b111
  } reg_sel_t;

  // per-event decode result handed from the register stage to the pipeline
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [MAP_W-1:0]    mapped;
    logic                irq;
    logic                ram_rd;
    logic                ram_wr;
  } ev_result_t;

endpackage

// File: rtl/core/bmsi_ram.sv
// ----------------------------------------------------------------------------
// bmsi_ram
// single-port prg work ram, registered read data, no reset of contents
// ----------------------------------------------------------------------------
module bmsi_ram #(
  parameter int unsigned RAM_DEPTH = bmsi_pkg::RAM_DEPTH_DEFAULT,
  parameter int unsigned AW        = $clog2(RAM_DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [AW-1:0]               addr,
  input  logic [bmsi_pkg::DATA_W-1:0] wdata,
  output logic [bmsi_pkg::DATA_W-1:0] rdata
);

  logic [bmsi_pkg::DATA_W-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/bmsi_regs.sv
// ----------------------------------------------------------------------------
// bmsi_regs
// mapper control registers, scanline counter and address translation
// ----------------------------------------------------------------------------
module bmsi_regs #(
  parameter int unsigned RAM_DEPTH = bmsi_pkg::RAM_DEPTH_DEFAULT,
  parameter int unsigned AW        = $clog2(RAM_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [bmsi_pkg::MODE_W-1:0] mode,
  input  logic [bmsi_pkg::ADDR_W-1:0] address,
  input  logic [bmsi_pkg::DATA_W-1:0] write_data,
  output bmsi_pkg::ev_result_t        res,
  output logic [AW-1:0]               ram_idx
);

  localparam logic [15:0] D1 = 16'(RAM_DEPTH);
  localparam logic [15:0] D2 = 16'(2 * RAM_DEPTH);
  localparam logic [15:0] D4 = 16'(4 * RAM_DEPTH);

  logic [7:0] bank_mode,      bank_mode_next;
  logic [5:0] prg_banks [2],  prg_banks_next [2];
  logic [7:0] chr_banks [6],  chr_banks_next [6];
  logic       mirroring,      mirroring_next;
  logic       ram_enabled,    ram_enabled_next;
  logic       ram_protected,  ram_protected_next;
  logic [7:0] reload_value,   reload_value_next;
  logic [7:0] scanline_count, scanline_count_next;
  logic       irq_enabled,    irq_enabled_next;
  logic [2:0] edge_filter,    edge_filter_next;
  logic       irq_pending,    irq_pending_next;
  logic       last_a12,       last_a12_next;

  logic        ram_win;
  logic [15:0] r0, r1, r2, r3;
  logic [5:0]  rom_page;
  logic [18:0] rom_addr;
  logic [2:0]  slot;
  logic [2:0]  chr_sel;
  logic [10:0] chr_off;
  logic [18:0] pattern_addr;
  logic [18:0] nt_addr;
  logic        a12;
  logic [2:0]  bsel;
  logic [7:0]  cnt_dec;

  // offset modulo depth: quotient is below eight, three conditional subtracts
  always_comb begin
    r0 = {3'b000, address[12:0]};
    r1 = (r0 >= D4) ? r0 - D4 : r0;
    r2 = (r1 >= D2) ? r1 - D2 : r1;
    r3 = (r2 >= D1) ? r2 - D1 : r2;
  end
  assign ram_idx = r3[AW-1:0];
  assign ram_win = (address[15:13] == 3'b011);

  // prg rom mapping
  always_comb begin
    if (!address[15]) begin
      rom_page = bmsi_pkg::PRG_BANK_LAST;
    end else begin
      unique case (address[14:13])
        2'b00:   rom_page = bank_mode[6] ? bmsi_pkg::PRG_BANK_SECOND_LAST : prg_banks[0];
        2'b01:   rom_page = prg_banks[1];
        2'b10:   rom_page = bank_mode[6] ? prg_banks[0] : bmsi_pkg::PRG_BANK_SECOND_LAST;
        default: rom_page = bmsi_pkg::PRG_BANK_LAST;
      endcase
    end
    rom_addr = {rom_page, address[12:0]};
  end

  // chr mapping, two 2k slots and four 1k slots, halves swapped by bank_mode[7]
  always_comb begin
    slot = address[12:10] ^ {bank_mode[7], 2'b00};
    if (!slot[2]) begin
      chr_sel = {2'b00, slot[1]};
      chr_off = address[10:0];
    end else begin
      chr_sel = slot - 3'd2;
      chr_off = {1'b0, address[9:0]};
    end
    pattern_addr = {1'b0, chr_banks[chr_sel], 10'b0} | {8'b0, chr_off};
  end

  // nametable mirroring
  always_comb begin
    if (mirroring) begin
      nt_addr = {8'b0, address[11], address[9:0]};
    end else begin
      nt_addr = {8'b0, address[10], address[9:0]};
    end
  end

  assign a12     = address[12];
  assign bsel    = bank_mode[2:0];
  assign cnt_dec = scanline_count - 8'd1;

  always_comb begin
    bank_mode_next      = bank_mode;
    prg_banks_next      = prg_banks;
    chr_banks_next      = chr_banks;
    mirroring_next      = mirroring;
    ram_enabled_next    = ram_enabled;
    ram_protected_next  = ram_protected;
    reload_value_next   = reload_value;
    scanline_count_next = scanline_count;
    irq_enabled_next    = irq_enabled;
    edge_filter_next    = edge_filter;
    irq_pending_next    = irq_pending;
    last_a12_next       = last_a12;
    res                 = '0;

    unique case (mode)
      bmsi_pkg::MODE_TICK: begin
        if (edge_filter != 3'd0) begin
          edge_filter_next = edge_filter - 3'd1;
        end
      end
      bmsi_pkg::MODE_CPU_RD: begin
        priority if (ram_win && ram_enabled) begin
          res.target = bmsi_pkg::TGT_PRG_RAM;
          res.mapped = 19'(ram_idx);
          res.ram_rd = 1'b1;
        end else if (address[15]) begin
          res.target = bmsi_pkg::TGT_PRG_ROM;
          res.mapped = rom_addr;
        end else begin
          res.target = bmsi_pkg::TGT_OPEN_BUS;
        end
      end
      bmsi_pkg::MODE_CPU_WR: begin
        if (ram_win && ram_enabled && !ram_protected) begin
          res.target = bmsi_pkg::TGT_PRG_RAM;
          res.mapped = 19'(ram_idx);
          res.ram_wr = 1'b1;
        end
        if (address[15]) begin
          unique case (bmsi_pkg::reg_sel_t'({address[14:13], address[0]}))
            bmsi_pkg::REG_BANK_SEL: bank_mode_next = write_data & 8'hc7;
            bmsi_pkg::REG_BANK_DATA: begin
              if (bsel[2:1] == 2'b11) begin
                prg_banks_next[bsel[0]] = write_data[5:0];
              end
              for (int i = 0; i < 6; i++) begin
                if (bsel == 3'(i)) begin
                  chr_banks_next[i] = (i < 2) ? (write_data & 8'hfe) : write_data;
                end
              end
            end
            bmsi_pkg::REG_MIRROR: mirroring_next = write_data[0];
            bmsi_pkg::REG_RAM_CTRL: begin
              ram_enabled_next   = write_data[7];
              ram_protected_next = write_data[6];
            end
            bmsi_pkg::REG_IRQ_LATCH:  reload_value_next   = write_data;
            bmsi_pkg::REG_IRQ_RELOAD: scanline_count_next = 8'd0;
            bmsi_pkg::REG_IRQ_DIS: begin
              irq_enabled_next = 1'b0;
              irq_pending_next = 1'b0;
            end
            bmsi_pkg::REG_IRQ_EN: irq_enabled_next = 1'b1;
            default: ;
          endcase
        end
      end
      bmsi_pkg::MODE_PPU_RD, bmsi_pkg::MODE_PPU_WR: begin
        // rising a12 clocks the counter once the filter has run out
        if (!last_a12 && a12) begin
          if (edge_filter == 3'd0) begin
            if (scanline_count == 8'd0) begin
              scanline_count_next = reload_value;
            end else begin
              scanline_count_next = cnt_dec;
              if (cnt_dec == 8'd0 && irq_enabled) begin
                irq_pending_next = 1'b1;
              end
            end
          end
          edge_filter_next = bmsi_pkg::FILTER_RELOAD;
        end
        last_a12_next = a12;
        if (address[13]) begin
          res.target = bmsi_pkg::TGT_NAMETBL;
          res.mapped = nt_addr;
        end else begin
          res.target = bmsi_pkg::TGT_CHR;
          res.mapped = pattern_addr;
        end
      end
      default: ;
    endcase
    res.irq = irq_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_mode      <= '0;
      prg_banks      <= '{default: '0};
      chr_banks      <= '{default: '0};
      mirroring      <= 1'b0;
      ram_enabled    <= 1'b1;
      ram_protected  <= 1'b0;
      reload_value   <= '0;
      scanline_count <= '0;
      irq_enabled    <= 1'b0;
      edge_filter    <= '0;
      irq_pending    <= 1'b0;
      last_a12       <= 1'b0;
    end else if (fire) begin
      bank_mode      <= bank_mode_next;
      prg_banks      <= prg_banks_next;
      chr_banks      <= chr_banks_next;
      mirroring      <= mirroring_next;
      ram_enabled    <= ram_enabled_next;
      ram_protected  <= ram_protected_next;
      reload_value   <= reload_value_next;
      scanline_count <= scanline_count_next;
      irq_enabled    <= irq_enabled_next;
      edge_filter    <= edge_filter_next;
      irq_pending    <= irq_pending_next;
      last_a12       <= last_a12_next;
    end
  end

endmodule

// File: rtl/core/bank_mapper_with_scanline_irq_unit.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_unit
// bank-switching mapper with prg work ram and a12 scanline interrupt counter
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | sink      | in_valid / in_ready  | mode, address, write_data
//   out     | source    | out_valid / out_ready| target, mapped_address,
//           |           |                      | read_data, irq
//
//   one event per cycle sustained while out_ready holds; each result passes through
//   the read stage (registered work ram read) and then the output register
//   register updates and ram writes take effect at the input transfer edge, so
//   a read right after a write to the same ram entry sees the new byte
//   reset clears all control registers and the pipeline; ram contents persist
//   a stall on out backs up one event in the read stage, then in_ready drops
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq_unit #(
  parameter int unsigned RAM_DEPTH = bmsi_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmsi_pkg::MODE_W-1:0]   mode,
  input  logic [bmsi_pkg::ADDR_W-1:0]   address,
  input  logic [bmsi_pkg::DATA_W-1:0]   write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmsi_pkg::TARGET_W-1:0] target,
  output logic [bmsi_pkg::MAP_W-1:0]    mapped_address,
  output logic [bmsi_pkg::DATA_W-1:0]   read_data,
  output logic                          irq
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  logic                       in_fire;
  bmsi_pkg::ev_result_t       ev;
  logic [AW-1:0]              ram_idx;
  logic [bmsi_pkg::DATA_W-1:0] ram_q;

  // read stage: waits for the registered ram data
  logic                 s1_valid;
  bmsi_pkg::ev_result_t s1;
  logic                 s1_adv;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // control registers, counter and address translation
  bmsi_regs #(
    .RAM_DEPTH (RAM_DEPTH),
    .AW        (AW)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .res        (ev),
    .ram_idx    (ram_idx)
  );

  // read data only refreshes on a transfer, so it holds while the stage stalls
  bmsi_ram #(
    .RAM_DEPTH (RAM_DEPTH),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .wr_en (in_fire && ev.ram_wr),
    .rd_en (in_fire && ev.ram_rd),
    .addr  (ram_idx),
    .wdata (write_data),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= ev;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      target         <= s1.target;
      mapped_address <= s1.mapped;
      read_data      <= s1.ram_rd ? ram_q : '0;
      irq            <= s1.irq;
    end
  end

  // read data is only ever nonzero on a prg ram access
  a_rdata_only_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target != bmsi_pkg::TGT_PRG_RAM) |-> read_data == '0)
    else $error("read data outside a prg ram access");

  // no translated address for none or open bus
  a_map_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target == bmsi_pkg::TGT_NONE || target == bmsi_pkg::TGT_OPEN_BUS)
    |-> mapped_address == '0)
    else $error("mapped address set without a target");

  // empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // a stalled read stage keeps its event
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("read stage event lost during stall");

  // ram is never read and written by the same event
  a_ram_excl: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !(ev.ram_rd && ev.ram_wr))
    else $error("ram read and write in one event");

endmodule

// File: tb/tb_bank_mapper_with_scanline_irq_unit.sv
// ----------------------------------------------------------------------------
// tb_bank_mapper_with_scanline_irq_unit
// checks the bank mapper against a cycle-free model of its registers, address
// translation, prg work ram and a12 scanline counter; results are compared in
// order, on every field, while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_bank_mapper_with_scanline_irq_unit;
  import bmsi_pkg::*;

  localparam int unsigned RAM_DEPTH      = RAM_DEPTH_DEFAULT;
  localparam int unsigned PIPE_LATENCY   = 2;     // transfer in to result out
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int unsigned OUT_HOLD       = 80;    // long output stall, in cycles
  localparam int unsigned MAX_REPORTS    = 10;

  // bus modes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // cpu window 0x6000-0x7fff holding the work ram
  localparam logic [2:0] WIN_WRAM = 3'b011;

  typedef struct packed {
    logic [TARGET_W-1:0] tgt;
    logic [MAP_W-1:0]    addr;
    logic [DATA_W-1:0]   data;
    logic                irq;
  } bus_result_t;

  // dut ports; the inputs are driven to known values from time zero
  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode       = '0;
  logic [ADDR_W-1:0]   address    = '0;
  logic [DATA_W-1:0]   write_data = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [TARGET_W-1:0] target;
  logic [MAP_W-1:0]    mapped_address;
  logic [DATA_W-1:0]   read_data;
  logic                irq;

  // mapper state as the predictor sees it
  logic [7:0]  sel_reg;       // bank select: invert chr, swap prg, slot index
  logic [5:0]  prg_page [2];
  logic [7:0]  chr_page [6];
  logic        mirror_h;
  logic        wram_on;
  logic        wram_ro;
  logic [7:0]  latch_value;
  logic [7:0]  line_ctr;
  logic        irq_armed;
  logic [2:0]  a12_guard;     // edge filter, counts down on cpu ticks
  logic        irq_flag;
  logic        a12_prev;
  logic [7:0]  wram [RAM_DEPTH];
  bit          wram_known [RAM_DEPTH];
  int unsigned wram_used [$]; // ram entries holding a byte we wrote

  bus_result_t bus_results_due [$];

  // run control and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned events_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned ram_reads     = 0;
  int unsigned irq_high      = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  bank_mapper_with_scanline_irq_unit #(
    .RAM_DEPTH(RAM_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .address(address),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target(target),
    .mapped_address(mapped_address),
    .read_data(read_data),
    .irq(irq)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_mapper_state();
    sel_reg     = '0;
    prg_page    = '{default: '0};
    chr_page    = '{default: '0};
    mirror_h    = 1'b0;
    wram_on     = 1'b1;
    wram_ro     = 1'b0;
    latch_value = '0;
    line_ctr    = '0;
    irq_armed   = 1'b0;
    a12_guard   = '0;
    irq_flag    = 1'b0;
    a12_prev    = 1'b0;
  endfunction

  // 8 kb windows: 0x8000 and 0xc000 trade places with the second last bank
  function automatic logic [MAP_W-1:0] prg_rom_addr(input logic [15:0] a);
    logic [5:0] page;
    case (a[15:13])
      3'b100:  page = sel_reg[6] ? PRG_BANK_SECOND_LAST : prg_page[0];
      3'b101:  page = prg_page[1];
      3'b110:  page = sel_reg[6] ? prg_page[0] : PRG_BANK_SECOND_LAST;
      default: page = PRG_BANK_LAST;
    endcase
    return {page, a[12:0]};
  endfunction

  // two 2 kb slots then four 1 kb slots, halves swapped by the invert bit
  function automatic logic [MAP_W-1:0] pattern_addr(input logic [13:0] p);
    logic [2:0] slot;
    logic [7:0] page;
    slot = p[12:10];
    if (sel_reg[7]) begin
      slot[2] = ~slot[2];
    end
    if (!slot[2]) begin
      page = chr_page[slot[1]];
      return (MAP_W'(page) << 10) | MAP_W'(p[10:0]);
    end
    page = chr_page[int'(slot) - 2];
    return (MAP_W'(page) << 10) | MAP_W'(p[9:0]);
  endfunction

  // horizontal mirroring folds on a11, vertical on a10
  function automatic logic [MAP_W-1:0] nt_fold_addr(input logic [13:0] p);
    return mirror_h ? MAP_W'({p[11], p[9:0]}) : MAP_W'({p[10], p[9:0]});
  endfunction

  function automatic void clock_line_counter(input logic a12);
    if (!a12_prev && a12) begin
      if (a12_guard == 0) begin
        if (line_ctr == 0) begin
          line_ctr = latch_value;          // reload alone never raises irq
        end else begin
          line_ctr = line_ctr - 8'd1;
          if (line_ctr == 0 && irq_armed) begin
            irq_flag = 1'b1;
          end
        end
      end
      a12_guard = FILTER_RELOAD;           // every rise restarts the filter
    end
    a12_prev = a12;
  endfunction

  function automatic void apply_reg_write(input logic [15:0] a, input logic [7:0] d);
    case (reg_sel_t'({a[14:13], a[0]}))
      REG_BANK_SEL:   sel_reg = {d[7:6], 3'b000, d[2:0]};
      REG_BANK_DATA: begin
        if (sel_reg[2:0] < 3'd2) begin
          chr_page[sel_reg[2:0]] = {d[7:1], 1'b0};
        end else if (sel_reg[2:0] < 3'd6) begin
          chr_page[sel_reg[2:0]] = d;
        end else begin
          prg_page[sel_reg[0]] = d[5:0];
        end
      end
      REG_MIRROR:     mirror_h = d[0];
      REG_RAM_CTRL: begin
        wram_on = d[7];
        wram_ro = d[6];
      end
      REG_IRQ_LATCH:  latch_value = d;
      REG_IRQ_RELOAD: line_ctr = '0;
      REG_IRQ_DIS: begin
        irq_armed = 1'b0;
        irq_flag  = 1'b0;
      end
      default:        irq_armed = 1'b1;
    endcase
  endfunction

  // advances the model by one bus event and returns the result it must give
  function automatic bus_result_t predict_access(input logic [MODE_W-1:0] md,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d);
    bus_result_t r;
    int unsigned idx;
    logic        in_wram;
    r       = '0;
    idx     = a[12:0] % RAM_DEPTH;
    in_wram = (a[15:13] == WIN_WRAM);
    case (md)
      MODE_TICK: begin
        if (a12_guard != 0) begin
          a12_guard = a12_guard - 3'd1;
        end
      end
      MODE_CPU_RD: begin
        if (in_wram && wram_on) begin
          r.tgt  = TGT_PRG_RAM;
          r.addr = MAP_W'(idx);
          r.data = wram[idx];
          ram_reads++;
        end else if (a[15]) begin
          r.tgt  = TGT_PRG_ROM;
          r.addr = prg_rom_addr(a);
        end else begin
          r.tgt  = TGT_OPEN_BUS;
        end
      end
      MODE_CPU_WR: begin
        if (in_wram && wram_on && !wram_ro) begin
          wram[idx] = d;
          if (!wram_known[idx]) begin
            wram_known[idx] = 1'b1;
            wram_used.push_back(idx);
          end
          r.tgt  = TGT_PRG_RAM;
          r.addr = MAP_W'(idx);
        end
        if (a[15]) begin
          apply_reg_write(a, d);
        end
      end
      MODE_PPU_RD, MODE_PPU_WR: begin
        clock_line_counter(a[12]);
        if (a[13]) begin
          r.tgt  = TGT_NAMETBL;
          r.addr = nt_fold_addr(a[13:0]);
        end else begin
          r.tgt  = TGT_CHR;
          r.addr = pattern_addr(a[13:0]);
        end
      end
      default: ;                           // spare modes leave everything alone
    endcase
    r.irq = irq_flag;
    if (irq_flag) begin
      irq_high++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one bus event per call, random gaps before it
  // ---------------------------------------------------------------------------

  task automatic bus_transfer(input logic [MODE_W-1:0] md, input logic [15:0] a,
                              input logic [7:0] d);
    int unsigned idx;
    idx = a[12:0] % RAM_DEPTH;
    // never read a ram byte that was never written: steer to a known one,
    // or to the rom window when nothing has been written yet
    if (md == MODE_CPU_RD && a[15:13] == WIN_WRAM && wram_on && !wram_known[idx]) begin
      if (wram_used.size() != 0) begin
        a = {WIN_WRAM, 13'(wram_used[$urandom_range(wram_used.size() - 1, 0)])};
      end else begin
        a[15] = 1'b1;
      end
    end
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    mode       = md;
    address    = a;
    write_data = d;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    // transfer taken at this edge: the model moves on in the same order
    bus_results_due.push_back(predict_access(md, a, d));
    events_sent++;
  endtask

  function automatic logic [15:0] reg_addr(input reg_sel_t s, input logic [11:0] fill);
    return {1'b1, s[2:1], fill, s[0]};
  endfunction

  // stop offering, wait for every result, then let the pipe run empty
  task automatic settle_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (bus_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, plus a long hold when a test asks for one
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // every accepted result must match the oldest waiting prediction
  always @(posedge clk) begin : check_results
    bus_result_t want;
    bus_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {target, mapped_address, read_data, irq};
      results_seen++;
      if (bus_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: tgt=%0d addr=%05h data=%02h irq=%0d",
                   got.tgt, got.addr, got.data, got.irq);
        end
      end else begin
        want = bus_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on result %0d: want tgt=%0d addr=%05h data=%02h irq=%0d",
                     results_seen, want.tgt, want.addr, want.data, want.irq);
            $display("                        got  tgt=%0d addr=%05h data=%02h irq=%0d",
                     got.tgt, got.addr, got.data, got.irq);
          end
        end
      end
    end
  end

  // watchdog: a stretch with no transfer on either side means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, bus_results_due.size());
        $display("bank_mapper_with_scanline_irq_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // scanline counter: reload on first edge, filtered edge, then the irq
  task automatic test_scanline_irq();
    bus_transfer(MODE_CPU_WR, reg_addr(REG_IRQ_LATCH, 12'h000), 8'h01);
    bus_transfer(MODE_CPU_WR, reg_addr(REG_IRQ_EN, 12'hfff), 8'h00);
    bus_transfer(MODE_PPU_RD, 16'h1000, 8'h00);  // counter at zero: reload only
    bus_transfer(MODE_PPU_RD, 16'h0000, 8'h00);
    bus_transfer(MODE_PPU_WR, 16'h1000, 8'hff);  // inside the filter: no clock
    bus_transfer(MODE_PPU_RD, 16'h0fff, 8'h00);
    repeat (FILTER_RELOAD) bus_transfer(MODE_TICK, 16'hffff, 8'hff);
    bus_transfer(MODE_PPU_RD, 16'h1fff, 8'h00);  // counts to zero, irq goes high
    bus_transfer(MODE_SPARE_LAST, 16'h0000, 8'h00);
    bus_transfer(MODE_SPARE_FIRST, 16'h1000, 8'h00);
    bus_transfer(MODE_CPU_WR, reg_addr(REG_IRQ_DIS, 12'h000), 8'h00);
  endtask

  // first read of the last bank, then ram enable, protect and low writes
  task automatic test_ram_window();
    bus_transfer(MODE_CPU_RD, 16'hffff, 8'h00);
    bus_transfer(MODE_CPU_WR, 16'h7fff, 8'hff);
    bus_transfer(MODE_CPU_RD, 16'h7fff, 8'h00);
    bus_transfer(MODE_CPU_WR, 16'h5fff, 8'h12);  // below the window: ignored
    bus_transfer(MODE_CPU_WR, reg_addr(REG_RAM_CTRL, 12'h000), 8'h00);
    bus_transfer(MODE_CPU_RD, 16'h6000, 8'h00);  // disabled: open bus
    bus_transfer(MODE_CPU_WR, reg_addr(REG_RAM_CTRL, 12'h000), 8'hc0);
    bus_transfer(MODE_CPU_WR, 16'h7fff, 8'h33);  // protected: dropped
    bus_transfer(MODE_CPU_WR, reg_addr(REG_RAM_CTRL, 12'h000), 8'h80);
    bus_transfer(MODE_CPU_RD, 16'h7fff, 8'h00);
  endtask

  // swap and invert bits, top prg slot, mirroring
  task automatic test_bank_registers();
    bus_transfer(MODE_CPU_WR, reg_addr(REG_BANK_SEL, 12'h000), 8'hff);
    bus_transfer(MODE_CPU_WR, reg_addr(REG_BANK_DATA, 12'h000), 8'hff);
    bus_transfer(MODE_CPU_RD, 16'h8000, 8'h00);
    bus_transfer(MODE_CPU_WR, reg_addr(REG_MIRROR, 12'h000), 8'h01);
    bus_transfer(MODE_PPU_WR, 16'h3fff, 8'h5a);
  endtask

  // mostly well-formed traffic: scanline bursts, bank pairs, ram use
  task automatic test_random_traffic(input int unsigned n);
    int unsigned     goal;
    int unsigned     kind;
    int unsigned     ticks;
    reg_sel_t        rs;
    logic [15:0]     a;
    logic [7:0]      d;
    logic [MODE_W-1:0] md;
    goal = events_sent + n;
    while (events_sent < goal) begin
      kind = $urandom_range(99, 0);
      a    = 16'($urandom);
      d    = 8'($urandom);
      if (kind < 20) begin
        // one scanline: cpu ticks, then a12 low and high from the ppu
        ticks = $urandom_range(8, 0);
        repeat (ticks) bus_transfer(MODE_TICK, 16'($urandom), 8'($urandom));
        md = $urandom_range(1, 0) ? MODE_PPU_RD : MODE_PPU_WR;
        a[12] = 1'b0;
        bus_transfer(md, a, d);
        a = 16'($urandom);
        a[12] = 1'b1;
        bus_transfer(md, a, d);
      end else if (kind < 35) begin
        bus_transfer(MODE_CPU_WR, reg_addr(REG_BANK_SEL, 12'($urandom)), d);
        bus_transfer(MODE_CPU_WR, reg_addr(REG_BANK_DATA, 12'($urandom)), 8'($urandom));
      end else if (kind < 45) begin
        rs = reg_sel_t'($urandom_range(REG_IRQ_EN, REG_MIRROR));
        // keep ram usable and the latch short most of the time
        if (rs == REG_RAM_CTRL && $urandom_range(3, 0) != 0) begin
          d[7:6] = 2'b10;
        end else if (rs == REG_IRQ_LATCH && $urandom_range(3, 0) != 0) begin
          d = 8'($urandom_range(3, 0));
        end
        bus_transfer(MODE_CPU_WR, reg_addr(rs, 12'($urandom)), d);
      end else if (kind < 60) begin
        if ($urandom_range(1, 0)) begin
          a[12:0] = 13'($urandom_range(63, 0));
        end
        a[15:13] = WIN_WRAM;
        bus_transfer(MODE_CPU_WR, a, d);
      end else if (kind < 72) begin
        if (wram_used.size() != 0) begin
          a[12:0] = 13'(wram_used[$urandom_range(wram_used.size() - 1, 0)]);
        end
        a[15:13] = WIN_WRAM;
        bus_transfer(MODE_CPU_RD, a, d);
      end else if (kind < 82) begin
        bus_transfer(MODE_CPU_RD, a, d);
      end else if (kind < 92) begin
        bus_transfer($urandom_range(1, 0) ? MODE_PPU_RD : MODE_PPU_WR, a, d);
      end else begin
        // noise: any mode, spare ones included, at any address
        bus_transfer(MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_TICK)), a, d);
      end
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the pipe fills and in_ready drops
  task automatic test_output_backpressure();
    int unsigned saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_left     = OUT_HOLD;
    test_random_traffic(30);
    send_idle_pct = saved_idle;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_mapper_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender idles lightly, receiver heavily
    send_idle_pct = 14;
    recv_idle_pct = 47;
    test_scanline_irq();
    test_ram_window();
    test_bank_registers();
    test_output_backpressure();
    settle_outputs();                      // sender pauses until all results are in
    test_random_traffic(640);
    settle_outputs();

    // the other way round
    send_idle_pct = 47;
    recv_idle_pct = 14;
    test_random_traffic(660);
    settle_outputs();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(660);
    settle_outputs();

    $display("covered %0d bus events, %0d results checked, %0d work ram reads,",
             events_sent, results_seen, ram_reads);
    $display("%0d results with irq high, three idle mixes and a %0d-cycle output hold",
             irq_high, OUT_HOLD);
    if (mismatches == 0 && bus_results_due.size() == 0) begin
      $display("bank_mapper_with_scanline_irq_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               bus_results_due.size());
      $display("bank_mapper_with_scanline_irq_unit test failed");
    end
    $finish;
  end

endmodule
